// ===== sv/fmc_pkg.sv =====
package fmc_pkg;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int CRC_W   = 16;

    // Default store depth and the largest frame that the store is used for.
    localparam int DEF_BUFFER_DEPTH = 64;
    localparam int EVENT_CAP        = 64;
    localparam int TRAILER_BYTES    = 3;
    localparam int MIN_LEN_FLOOR    = 4;

    localparam logic [CRC_W-1:0] CRC_SEED = 16'hffff;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_VALUE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_MASK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0]  RST_SYNC_BYTE  = 8'd126;
    localparam logic [BYTE_W-1:0]  RST_DEST_VALUE = 8'd16;
    localparam logic [BYTE_W-1:0]  RST_SEQ_MASK   = 8'd15;
    localparam logic [COUNT_W-1:0] RST_MIN_LENGTH = 7'd5;
    localparam logic [COUNT_W-1:0] RST_MAX_LENGTH = 7'd64;

    // Event kinds.
    localparam logic EV_FRAME   = 1'b0;
    localparam logic EV_DISCARD = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0]  sync_byte;
        logic [BYTE_W-1:0]  dest_value;
        logic [BYTE_W-1:0]  seq_mask;
        logic [COUNT_W-1:0] min_length;
        logic [COUNT_W-1:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  seq;
    } event_t;

    // One byte of the reflected CCITT update.
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = b ^ crc[7:0];
        d = d ^ {d[3:0], 4'b0000};
        crc_step = {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b000};
    endfunction

endpackage

// ===== sv/fmc_ram.sv =====
module fmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/fmc_front.sv =====
module fmc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [fmc_pkg::BYTE_W-1:0] s_tdata,
    output logic                      q_valid,
    output logic [fmc_pkg::BYTE_W-1:0] q_data,
    input  logic                      q_pop
);
    import fmc_pkg::*;

    logic [BYTE_W-1:0] slot_reg [2];
    logic [1:0]        count_reg, count_next;
    logic              wr_ptr_reg, rd_ptr_reg;
    logic              push;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = slot_reg[rd_ptr_reg];

    // Occupancy of the two-entry request queue.
    always_comb begin
        count_next = count_reg;
        if (push && !(q_pop && q_valid)) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop && q_valid) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Payload slots.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_tdata;
        end
    end

endmodule

// ===== sv/fmc_engine.sv =====
module fmc_engine #(
    parameter int BUFFER_DEPTH = fmc_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fmc_pkg::cfg_t              cfg,
    input  logic                       q_valid,
    input  logic [fmc_pkg::BYTE_W-1:0] q_data,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output fmc_pkg::event_t            m_event,
    output logic                       m_last
);
    import fmc_pkg::*;

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int SW  = AW + 1;
    localparam int CAP = (BUFFER_DEPTH < EVENT_CAP) ? BUFFER_DEPTH : EVENT_CAP;
    localparam logic [COUNT_W-1:0] CAP_C   = COUNT_W'(CAP);
    localparam logic [COUNT_W-1:0] FLOOR_C = COUNT_W'(MIN_LEN_FLOOR);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD0      = 4'd1;
    localparam logic [3:0] S_RD1      = 4'd2;
    localparam logic [3:0] S_RD2      = 4'd3;
    localparam logic [3:0] S_DECIDE   = 4'd4;
    localparam logic [3:0] S_WALK_RD  = 4'd5;
    localparam logic [3:0] S_WALK_CMP = 4'd6;
    localparam logic [3:0] S_EMIT     = 4'd7;
    localparam logic [3:0] S_END      = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic               hunting_reg, hunting_next;
    logic [BYTE_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0]  seq_reg, seq_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               scan_reg, scan_next;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [CRC_W-1:0]   got_reg, got_next;
    event_t             ev_reg, ev_next;
    event_t             pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    event_t             out_reg, out_next;
    logic               out_last_reg, out_last_next;
    logic               m_valid_reg, m_valid_next;

    logic [COUNT_W-1:0] lo_raw, lo, hi;
    logic               out_free, bad;
    logic [COUNT_W-1:0] rd_off;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [BYTE_W-1:0]  rd_data;
    logic               wr_en;
    logic [BYTE_W-1:0]  idx8;

    // Circular store index: head plus an offset no larger than the depth.
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                           input logic [COUNT_W-1:0] off);
        logic [SW:0] sum;
        sum = {1'b0, {1'b0, base}} + (SW+1)'(off);
        if (sum >= (SW+1)'(BUFFER_DEPTH)) begin
            sum = sum - (SW+1)'(BUFFER_DEPTH);
        end
        wrap = sum[AW-1:0];
    endfunction

    fmc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (q_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Length limits clamped to the usable store.
    assign lo_raw = (cfg.min_length < FLOOR_C) ? FLOOR_C : cfg.min_length;
    assign lo     = (lo_raw > CAP_C) ? CAP_C : lo_raw;
    assign hi     = (cfg.max_length > CAP_C) ? CAP_C : cfg.max_length;

    assign out_free = !m_valid_reg || m_tready;
    assign idx8     = {1'b0, idx_reg};

    // Header checks on the frame at the head of the store.
    assign bad = hunting_reg
              || (len_reg < {1'b0, lo}) || (len_reg > {1'b0, hi})
              || ((seq_reg & ~cfg.seq_mask) != cfg.dest_value);

    // Store addressing.
    always_comb begin
        case (state_reg)
            S_RD0:   rd_off = '0;
            S_RD1:   rd_off = COUNT_W'(1);
            default: rd_off = idx_reg;
        endcase
    end
    assign rd_addr = wrap(head_reg, rd_off);
    assign wr_addr = wrap(head_reg, fill_reg);
    assign wr_en   = (state_reg == S_IDLE) && q_valid && (fill_reg < CAP_C);
    assign q_pop   = (state_reg == S_IDLE);

    // Sequencer of the back end.
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        hunting_next    = hunting_reg;
        len_next        = len_reg;
        seq_next        = seq_reg;
        idx_next        = idx_reg;
        scan_next       = scan_reg;
        crc_next        = crc_reg;
        got_next        = got_reg;
        ev_next         = ev_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    if (fill_reg < CAP_C) begin
                        fill_next = fill_reg + COUNT_W'(1);
                    end
                    state_next = S_RD0;
                end
            end
            S_RD0: begin
                state_next = (fill_reg < lo) ? S_END : S_RD1;
            end
            S_RD1: begin
                len_next   = rd_data;
                state_next = S_RD2;
            end
            S_RD2: begin
                seq_next   = rd_data;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                idx_next = '0;
                crc_next = CRC_SEED;
                if (bad) begin
                    scan_next  = 1'b1;
                    state_next = S_WALK_RD;
                end else if ({1'b0, fill_reg} < len_reg) begin
                    state_next = S_END;
                end else begin
                    scan_next  = 1'b0;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP: begin
                state_next = S_WALK_RD;
                idx_next   = idx_reg + COUNT_W'(1);
                if (scan_reg) begin
                    // Resync search for the first sync byte.
                    ev_next.kind = EV_DISCARD;
                    ev_next.seq  = '0;
                    if (rd_data == cfg.sync_byte) begin
                        ev_next.count = idx_reg + COUNT_W'(1);
                        hunting_next  = 1'b0;
                        state_next    = S_EMIT;
                    end else if (idx_reg + COUNT_W'(1) == fill_reg) begin
                        ev_next.count = fill_reg;
                        hunting_next  = 1'b1;
                        state_next    = S_EMIT;
                    end
                end else begin
                    // CRC over the body, then the trailer.
                    if (idx8 < len_reg - BYTE_W'(TRAILER_BYTES)) begin
                        crc_next = crc_step(crc_reg, rd_data);
                    end
                    if (idx8 == len_reg - BYTE_W'(3)) begin
                        got_next[15:8] = rd_data;
                    end
                    if (idx8 == len_reg - BYTE_W'(2)) begin
                        got_next[7:0] = rd_data;
                    end
                    if (idx8 == len_reg - BYTE_W'(1)) begin
                        if (rd_data == cfg.sync_byte && crc_reg == got_reg) begin
                            ev_next.kind  = EV_FRAME;
                            ev_next.count = len_reg[COUNT_W-1:0];
                            ev_next.seq   = seq_reg & cfg.seq_mask;
                            state_next    = S_EMIT;
                        end else begin
                            scan_next = 1'b1;
                            idx_next  = '0;
                        end
                    end
                end
            end
            S_EMIT: begin
                // Retire the held event, hold the new one, drop its bytes.
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_next      = pend_reg;
                        out_last_next = 1'b0;
                        m_valid_next  = 1'b1;
                    end
                    pend_next       = ev_reg;
                    pend_valid_next = 1'b1;
                    head_next       = wrap(head_reg, ev_reg.count);
                    fill_next       = fill_reg - ev_reg.count;
                    state_next      = S_RD0;
                end
            end
            S_END: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            hunting_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            hunting_reg    <= hunting_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Working registers and the result register.
    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        seq_reg      <= seq_next;
        idx_reg      <= idx_next;
        scan_reg     <= scan_next;
        crc_reg      <= crc_next;
        got_reg      <= got_next;
        ev_reg       <= ev_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_event  = out_reg;
    assign m_last   = out_last_reg;

    // The store never holds more than its usable capacity.
    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= CAP_C)
        else $error("fill count above capacity");

    // No event is held back while waiting for the next byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("held event while idle");

    // Every delivered event covers at least one byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> out_reg.count != '0)
        else $error("empty event");

    // An event never drops more bytes than the store holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> ev_reg.count <= fill_reg)
        else $error("event longer than held bytes");

endmodule

// ===== sv/framed_message_checker.sv =====
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   tdata[7:0] rx_byte
// m_        out  m_tvalid/m_tready   tuser event_kind, tdata byte_count/frame_seq,
//                                    tlast last
// cfg_      in   cfg_wr_en           cfg_index, cfg_wr_data
//
// After each byte the checker ends at once if fewer bytes than the minimum are held,
// else reads the header and ends if the frame is incomplete. Each walked byte has a
// read and a compare state, as one read port serves both the CRC walk and the resync
// search; a failed CRC walk is followed by a resync walk over the same bytes.
// A two-entry queue takes bytes while the checker works; the checker stalls only when
// a held event must move to the result register while that one still waits to be taken.
// Reset is synchronous and active low; the store content is not cleared.
module framed_message_checker #(
    parameter int BUFFER_DEPTH = fmc_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,     // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,     // [6:0] byte_count, [14:7] frame_seq
    output logic                          m_tuser,     // [0] event_kind
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [fmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wr_data
);
    import fmc_pkg::*;

    cfg_t              cfg_reg;
    logic              q_valid, q_pop;
    logic [BYTE_W-1:0] q_data;
    event_t            m_event;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte  <= RST_SYNC_BYTE;
            cfg_reg.dest_value <= RST_DEST_VALUE;
            cfg_reg.seq_mask   <= RST_SEQ_MASK;
            cfg_reg.min_length <= RST_MIN_LENGTH;
            cfg_reg.max_length <= RST_MAX_LENGTH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SYNC_BYTE:  cfg_reg.sync_byte  <= cfg_wr_data;
                REG_DEST_VALUE: cfg_reg.dest_value <= cfg_wr_data;
                REG_SEQ_MASK:   cfg_reg.seq_mask   <= cfg_wr_data;
                REG_MIN_LENGTH: cfg_reg.min_length <= cfg_wr_data[COUNT_W-1:0];
                REG_MAX_LENGTH: cfg_reg.max_length <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    fmc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    fmc_engine #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_event  (m_event),
        .m_last   (m_tlast)
    );

    // Result packing.
    assign m_tuser = m_event.kind;
    assign m_tdata = {1'b0, m_event.seq, m_event.count};

endmodule
